// File: rtl/pwc_pkg.sv
// ----------------------------------------------------------------------------
// pwc_pkg
// Shared types and constants for the four channel pulse width capture core.
// ----------------------------------------------------------------------------
package pwc_pkg;

  localparam int NUM_CH   = 4;
  localparam int CH_W     = $clog2(NUM_CH);
  localparam int CNT_W    = 14;
  localparam int STAMP_W  = 16;
  localparam int PER_W    = STAMP_W + 1;
  localparam int WIDTH_W  = 31;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [CNT_W-1:0]   CNT_MAX   = 14'h3FFF;
  localparam logic [STAMP_W-1:0] STAMP_MAX = 16'hFFFF;

  localparam logic [1:0] OP_OVF     = 2'd0;
  localparam logic [1:0] OP_CAP     = 2'd1;
  localparam logic [1:0] OP_COLLECT = 2'd2;

  typedef struct packed {
    logic               done;
    logic [CNT_W-1:0]   cnt;
    logic [STAMP_W-1:0] start;
    logic [STAMP_W-1:0] stop;
  } chan_t;

  typedef chan_t [NUM_CH-1:0] snap_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_DRAIN,
    BK_EMIT
  } bk_state_e;

endpackage

// File: rtl/pwc_front.sv
// ----------------------------------------------------------------------------
// pwc_front
// Accepts events, keeps per-channel capture status, and queues a snapshot
// of all channels on each collect.
// ----------------------------------------------------------------------------
module pwc_front import pwc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic [CH_W-1:0]    channel_i,
  input  logic [STAMP_W-1:0] stamp_i,
  input  q_stat_t            q_stat_i,
  output logic               push_o,
  output snap_t              snap_o
);

  logic [NUM_CH-1:0]  armed_q, armed_d;
  logic [NUM_CH-1:0]  done_q, done_d;
  logic [CNT_W-1:0]   cnt_q   [NUM_CH];
  logic [CNT_W-1:0]   cnt_d   [NUM_CH];
  logic [STAMP_W-1:0] start_q [NUM_CH];
  logic [STAMP_W-1:0] start_d [NUM_CH];
  logic [STAMP_W-1:0] stop_q  [NUM_CH];
  logic [STAMP_W-1:0] stop_d  [NUM_CH];
  logic               accept;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i & ~q_stat_i.full;

  always_comb begin
    armed_d = armed_q;
    done_d  = done_q;
    cnt_d   = cnt_q;
    start_d = start_q;
    stop_d  = stop_q;
    push_o  = 1'b0;
    if (accept) begin
      case (op_i)
        OP_OVF: begin
          for (int c = 0; c < NUM_CH; c++) begin
            if (armed_q[c] && !done_q[c]) begin
              if (cnt_q[c] == CNT_MAX) begin
                done_d[c] = 1'b1;
                stop_d[c] = STAMP_MAX;
              end else begin
                cnt_d[c] = cnt_q[c] + 1'b1;
              end
            end
          end
        end
        OP_CAP: begin
          if (armed_q[channel_i]) begin
            stop_d[channel_i] = stamp_i;
            done_d[channel_i] = 1'b1;
          end else begin
            start_d[channel_i] = stamp_i;
            cnt_d[channel_i]   = '0;
            done_d[channel_i]  = 1'b0;
            armed_d[channel_i] = 1'b1;
          end
        end
        OP_COLLECT: begin
          push_o  = 1'b1;
          armed_d = '0;
          done_d  = '0;
          for (int c = 0; c < NUM_CH; c++) begin
            cnt_d[c] = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      snap_o[c].done  = done_q[c];
      snap_o[c].cnt   = cnt_q[c];
      snap_o[c].start = start_q[c];
      snap_o[c].stop  = stop_q[c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= '0;
      done_q  <= '0;
      for (int c = 0; c < NUM_CH; c++) begin
        cnt_q[c]   <= '0;
        start_q[c] <= '0;
        stop_q[c]  <= '0;
      end
    end else begin
      armed_q <= armed_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
      start_q <= start_d;
      stop_q  <= stop_d;
    end
  end

endmodule

// File: rtl/pwc_queue.sv
// ----------------------------------------------------------------------------
// pwc_queue
// Short FIFO of collect snapshots between front and back.
// ----------------------------------------------------------------------------
module pwc_queue import pwc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  snap_t   snap_i,
  input  logic    pop_i,
  output snap_t   head_o,
  output q_stat_t stat_o
);

  snap_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign stat_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= snap_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!stat_o.full || pop_i))
    else $error("snapshot pushed into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("pop from empty queue");

endmodule

// File: rtl/pwc_back.sv
// ----------------------------------------------------------------------------
// pwc_back
// Computes widths of a collect snapshot one channel per cycle through a
// two-stage multiply/add pipe, holds the widths and drives the result.
// ----------------------------------------------------------------------------
module pwc_back import pwc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [STAMP_W-1:0] period_top_i,
  input  snap_t              head_i,
  input  q_stat_t            q_stat_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               processed_o,
  output logic [WIDTH_W-1:0] width_o [NUM_CH]
);

  bk_state_e state_q, state_d;
  logic [CH_W-1:0]    step_q;
  logic               issue, start_job, load_out;

  logic               a_valid_q, a_done_q, a_zero_q;
  logic [CH_W-1:0]    a_idx_q;
  logic [STAMP_W-1:0] a_start_q, a_stop_q;
  logic [WIDTH_W-1:0] a_prod_q;

  logic [WIDTH_W-1:0] held_q [NUM_CH];
  logic               any_q;
  logic               out_valid_q, processed_q;
  logic [WIDTH_W-1:0] out_w_q [NUM_CH];

  chan_t              cur;
  logic [PER_W-1:0]   per;
  logic [CNT_W-1:0]   nm1;
  logic [WIDTH_W-1:0] prod;
  logic [STAMP_W-1:0] w_abs;
  logic [WIDTH_W-1:0] w_ovf, w_new;

  assign cur  = head_i[step_q];
  assign per  = {1'b0, period_top_i} + 1'b1;
  assign nm1  = cur.cnt - 1'b1;
  assign prod = WIDTH_W'(nm1) * WIDTH_W'(per);

  assign w_abs = (a_stop_q >= a_start_q) ? (a_stop_q - a_start_q) : (a_start_q - a_stop_q);
  assign w_ovf = a_prod_q + WIDTH_W'(per) - WIDTH_W'(a_start_q) + WIDTH_W'(a_stop_q);
  assign w_new = a_zero_q ? WIDTH_W'(w_abs) : w_ovf;

  always_comb begin
    state_d   = state_q;
    issue     = 1'b0;
    start_job = 1'b0;
    load_out  = 1'b0;
    pop_o     = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!q_stat_i.empty) begin
          start_job = 1'b1;
          state_d   = BK_RUN;
        end
      end
      BK_RUN: begin
        issue = 1'b1;
        if (step_q == CH_W'(NUM_CH - 1)) begin
          state_d = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        state_d = BK_EMIT;
      end
      BK_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          pop_o    = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      step_q      <= '0;
      a_valid_q   <= 1'b0;
      any_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < NUM_CH; c++) begin
        held_q[c] <= '0;
      end
    end else begin
      state_q   <= state_d;
      a_valid_q <= issue;
      if (start_job) begin
        step_q <= '0;
      end else if (issue) begin
        step_q <= step_q + 1'b1;
      end
      if (start_job) begin
        any_q <= 1'b0;
      end else if (a_valid_q && a_done_q) begin
        any_q <= 1'b1;
      end
      if (a_valid_q && a_done_q) begin
        held_q[a_idx_q] <= w_new;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      a_idx_q   <= step_q;
      a_done_q  <= cur.done;
      a_zero_q  <= (cur.cnt == '0);
      a_start_q <= cur.start;
      a_stop_q  <= cur.stop;
      a_prod_q  <= prod;
    end
    if (load_out) begin
      processed_q <= any_q;
      out_w_q     <= held_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign processed_o = processed_q;
  assign width_o     = out_w_q;

  a_pipe_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q |-> $past(state_q) == BK_RUN)
    else $error("width pipe stage loaded outside of run");

  a_emit_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_EMIT |-> !a_valid_q)
    else $error("result emitted with width still in flight");

endmodule

// File: rtl/four_channel_pulse_width_capture_core.sv
// ----------------------------------------------------------------------------
// four_channel_pulse_width_capture_core
// Pulse width capture on four channels with decoupled event and width paths.
// ----------------------------------------------------------------------------
// Overflow and capture events are accepted every cycle while the snapshot
// queue is not full. A collect queues a channel snapshot (two entries deep);
// the back end then computes one channel width per cycle through a shared
// multiply/add pipe before the result transfer is offered. The input stalls
// only while both snapshot entries are occupied.
module four_channel_pulse_width_capture_core import pwc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [STAMP_W-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic [CH_W-1:0]    channel_i,
  input  logic [STAMP_W-1:0] stamp_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               processed_o,
  output logic [WIDTH_W-1:0] width_a_o,
  output logic [WIDTH_W-1:0] width_b_o,
  output logic [WIDTH_W-1:0] width_c_o,
  output logic [WIDTH_W-1:0] width_d_o
);

  logic [STAMP_W-1:0] period_top_q;
  logic               push, pop;
  snap_t              snap, head;
  q_stat_t            q_stat;
  logic [WIDTH_W-1:0] width [NUM_CH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_top_q <= STAMP_MAX;
    end else if (cfg_we_i) begin
      period_top_q <= cfg_wdata_i;
    end
  end

  pwc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .channel_i  (channel_i),
    .stamp_i    (stamp_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .snap_o     (snap)
  );

  pwc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .snap_i (snap),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (q_stat)
  );

  pwc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .period_top_i (period_top_q),
    .head_i       (head),
    .q_stat_i     (q_stat),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .processed_o  (processed_o),
    .width_o      (width)
  );

  assign width_a_o = width[0];
  assign width_b_o = width[1];
  assign width_c_o = width[2];
  assign width_d_o = width[3];

endmodule

// File: tb/tb_four_channel_pulse_width_capture_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_four_channel_pulse_width_capture_core
// Self-checking testbench for the four channel pulse width capture core.
// A short table of directed events (reset state, stamp extremes, overflow
// counting, recapture on a done channel, ignored opcodes) runs first,
// followed by random event streams under several period_top settings.
// Every collect transfer is checked against its pinned table expectation or
// a behavioral channel-state model, with random valid gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_four_channel_pulse_width_capture_core;
  import pwc_pkg::*;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         N_DIRECTED   = 25;
  localparam int         N_PHASES     = 8;
  localparam int         PHASE_ITEMS  = 140;
  localparam int         DRAIN_CYCLES = 16;
  localparam int         STUCK_LIMIT  = 2000;
  localparam logic [WIDTH_W-1:0] W_0   = 31'd0;
  localparam logic [WIDTH_W-1:0] W_MAX = 31'd65535;
  localparam logic [WIDTH_W-1:0] W_D   = 31'd114688;
  localparam logic [WIDTH_W-1:0] W_A   = 31'd512;

  typedef struct packed {
    logic                             processed;
    logic [NUM_CH-1:0][WIDTH_W-1:0]   width;
  } width_rec_t;

  typedef struct packed {
    logic [1:0]         opc;
    logic [CH_W-1:0]    ch;
    logic [STAMP_W-1:0] st;
    logic               pin;
    logic               proc;
    logic [WIDTH_W-1:0] wa;
    logic [WIDTH_W-1:0] wb;
    logic [WIDTH_W-1:0] wc;
    logic [WIDTH_W-1:0] wd;
  } stim_row_t;

  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{OP_COLLECT, 2'd0, 16'h0000, 1'b1, 1'b0, W_0,   W_0,   W_0, W_0},
    '{OP_UNUSED,  2'd3, 16'hFFFF, 1'b0, 1'b0, W_0,   W_0,   W_0, W_0},
    '{OP_CAP,     2'd0, 16'h0000, 1'b0, 1'b0, W_0,   W_0,   W_0, W_0},
    '{OP_CAP,     2'd0, 16'hFFFF, 1'b0, 1'b0, W_0,   W_0,   W_0, W_0},
    '{OP_CAP,     2'd1, 16'hFFFF, 1'b0, 1'b0, W_0,   W_0,   W_0, W_0},
    '{OP_CAP,     2'd1, 16'h0000, 1'b0, 1'b0, W_0,   W_0,   W_0, W_0},
    '{OP_CAP,     2'd2, 16'h1234, 1'b0, 1'b0, W_0,   W_0,   W_0, W_0},
    '{OP_CAP,     2'd2, 16'h1234, 1'b0, 1'b0, W_0,   W_0,   W_0, W_0},
    '{OP_OVF,     2'd0, 16'h0000, 1'b0, 1'b0, W_0,   W_0,   W_0, W_0},
    '{OP_COLLECT, 2'd0, 16'h0000, 1'b1, 1'b1, W_MAX, W_MAX, W_0, W_0},
    '{OP_COLLECT, 2'd2, 16'h0000, 1'b1, 1'b0, W_MAX, W_MAX, W_0, W_0},
    '{OP_CAP,     2'd3, 16'h8000, 1'b0, 1'b0, W_0,   W_0,   W_0, W_0},
    '{OP_OVF,     2'd0, 16'h0000, 1'b0, 1'b0, W_0,   W_0,   W_0, W_0},
    '{OP_OVF,     2'd0, 16'h0000, 1'b0, 1'b0, W_0,   W_0,   W_0, W_0},
    '{OP_CAP,     2'd3, 16'h4000, 1'b0, 1'b0, W_0,   W_0,   W_0, W_0},
    '{OP_COLLECT, 2'd0, 16'h0000, 1'b1, 1'b1, W_MAX, W_MAX, W_0, W_D},
    '{OP_CAP,     2'd0, 16'h0100, 1'b0, 1'b0, W_0,   W_0,   W_0, W_0},
    '{OP_CAP,     2'd0, 16'h0200, 1'b0, 1'b0, W_0,   W_0,   W_0, W_0},
    '{OP_CAP,     2'd0, 16'h0300, 1'b0, 1'b0, W_0,   W_0,   W_0, W_0},
    '{OP_OVF,     2'd0, 16'h0000, 1'b0, 1'b0, W_0,   W_0,   W_0, W_0},
    '{OP_COLLECT, 2'd0, 16'h0000, 1'b1, 1'b1, W_A,   W_MAX, W_0, W_D},
    '{OP_CAP,     2'd1, 16'h0005, 1'b0, 1'b0, W_0,   W_0,   W_0, W_0},
    '{OP_OVF,     2'd0, 16'h0000, 1'b0, 1'b0, W_0,   W_0,   W_0, W_0},
    '{OP_UNUSED,  2'd1, 16'h5A5A, 1'b0, 1'b0, W_0,   W_0,   W_0, W_0},
    '{OP_COLLECT, 2'd0, 16'h0000, 1'b1, 1'b0, W_A,   W_MAX, W_0, W_D}
  };

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               cfg_we    = 1'b0;
  logic [STAMP_W-1:0] cfg_wdata = '0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [1:0]         op        = OP_OVF;
  logic [CH_W-1:0]    channel   = '0;
  logic [STAMP_W-1:0] stamp     = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               processed;
  logic [WIDTH_W-1:0] width_a;
  logic [WIDTH_W-1:0] width_b;
  logic [WIDTH_W-1:0] width_c;
  logic [WIDTH_W-1:0] width_d;

  // pinned expectation travels with the payload of a directed row
  logic               pin_q     = 1'b0;
  width_rec_t         pin_res_q = '0;

  logic               ch_done  [NUM_CH];
  logic               ch_armed [NUM_CH];
  logic [CNT_W-1:0]   ch_ovf   [NUM_CH];
  logic [STAMP_W-1:0] ch_start [NUM_CH];
  logic [STAMP_W-1:0] ch_stop  [NUM_CH];
  logic [WIDTH_W-1:0] ch_width [NUM_CH];
  logic [STAMP_W-1:0] model_period;

  width_rec_t         pending_widths [$];
  logic [STAMP_W-1:0] cur_period = STAMP_MAX;
  int                 gap_pct    = 0;
  logic               quiet      = 1'b0;
  int                 stall_left = 0;
  int                 stuck_cycles = 0;
  int                 mismatch_cnt = 0;
  int                 items_accepted = 0;
  int                 records_checked = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  four_channel_pulse_width_capture_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .op_i        (op),
    .channel_i   (channel),
    .stamp_i     (stamp),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .processed_o (processed),
    .width_a_o   (width_a),
    .width_b_o   (width_b),
    .width_c_o   (width_c),
    .width_d_o   (width_d)
  );

  task automatic reset_model();
    for (int c = 0; c < NUM_CH; c++) begin
      ch_done[c]  = 1'b0;
      ch_armed[c] = 1'b0;
      ch_ovf[c]   = '0;
      ch_start[c] = '0;
      ch_stop[c]  = '0;
      ch_width[c] = '0;
    end
    model_period = STAMP_MAX;
  endtask

  task automatic predict_widths(input logic [1:0] opc, input logic [CH_W-1:0] ch,
                                input logic [STAMP_W-1:0] st, output bit has_res,
                                output width_rec_t res);
    logic [31:0] per;
    logic [31:0] n;
    logic [31:0] w;
    has_res = 1'b0;
    res     = '0;
    per     = {16'd0, model_period} + 32'd1;
    case (opc)
      OP_OVF: begin
        for (int c = 0; c < NUM_CH; c++) begin
          if (ch_armed[c] && !ch_done[c]) begin
            if (ch_ovf[c] == CNT_MAX) begin
              ch_done[c] = 1'b1;
              ch_stop[c] = STAMP_MAX;
            end else begin
              ch_ovf[c] = ch_ovf[c] + 1'b1;
            end
          end
        end
      end
      OP_CAP: begin
        if (ch_armed[ch]) begin
          ch_stop[ch] = st;
          ch_done[ch] = 1'b1;
        end else begin
          ch_start[ch] = st;
          ch_ovf[ch]   = '0;
          ch_done[ch]  = 1'b0;
          ch_armed[ch] = 1'b1;
        end
      end
      OP_COLLECT: begin
        for (int c = 0; c < NUM_CH; c++) begin
          if (ch_done[c]) begin
            res.processed = 1'b1;
            n = {18'd0, ch_ovf[c]};
            if (n != 0) begin
              w = (n - 32'd1) * per + (per - {16'd0, ch_start[c]}) + {16'd0, ch_stop[c]};
            end else if (ch_stop[c] >= ch_start[c]) begin
              w = {16'd0, ch_stop[c] - ch_start[c]};
            end else begin
              w = {16'd0, ch_start[c] - ch_stop[c]};
            end
            ch_width[c] = w[WIDTH_W-1:0];
          end
        end
        for (int c = 0; c < NUM_CH; c++) begin
          ch_done[c]  = 1'b0;
          ch_armed[c] = 1'b0;
          ch_ovf[c]   = '0;
          res.width[c] = ch_width[c];
        end
        has_res = 1'b1;
      end
      default: begin
      end
    endcase
  endtask

  // monitor: predictor on input transfers, checker on output transfers
  always @(posedge clk) begin : monitor
    bit         got;
    bit         moved;
    width_rec_t exp_r;
    width_rec_t act_r;
    moved = 1'b0;
    if (!rst_n) begin
      reset_model();
      moved = 1'b1;
    end else begin
      if (cfg_we) begin
        model_period = cfg_wdata;
        moved = 1'b1;
      end
      if (in_valid && !in_stall) begin
        predict_widths(op, channel, stamp, got, exp_r);
        if (got) pending_widths.push_back(pin_q ? pin_res_q : exp_r);
        items_accepted++;
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        act_r.processed = processed;
        act_r.width[0]  = width_a;
        act_r.width[1]  = width_b;
        act_r.width[2]  = width_c;
        act_r.width[3]  = width_d;
        if (pending_widths.size() == 0) begin
          $display("%0t: unexpected width transfer, processed %0b", $time, processed);
          mismatch_cnt++;
        end else begin
          exp_r = pending_widths.pop_front();
          records_checked++;
          if (act_r.processed !== exp_r.processed) begin
            $display("%0t: processed expected %0b actual %0b", $time,
                     exp_r.processed, act_r.processed);
            mismatch_cnt++;
          end
          for (int c = 0; c < NUM_CH; c++) begin
            if (act_r.width[c] !== exp_r.width[c]) begin
              $display("%0t: width ch%0d expected %0d actual %0d", $time, c,
                       exp_r.width[c], act_r.width[c]);
              mismatch_cnt++;
            end
          end
        end
      end
    end
    stuck_cycles = moved ? 0 : stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (quiet || !rst_n) begin
      stall_left = 0;
    end else if (stall_left == 0 && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 10);
    end
    out_stall <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  task automatic send_item(input logic [1:0] opc, input logic [CH_W-1:0] ch,
                           input logic [STAMP_W-1:0] st, input logic pin,
                           input width_rec_t pres);
    in_valid  <= 1'b1;
    op        <= opc;
    channel   <= ch;
    stamp     <= st;
    pin_q     <= pin;
    pin_res_q <= pres;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_widths.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_period(input logic [STAMP_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [STAMP_W-1:0] pick_stamp();
    logic [STAMP_W-1:0] s;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: s = '0;
          1: s = STAMP_MAX;
          2: s = cur_period;
          default: s = cur_period + 1'b1;
        endcase
      end
      1, 2: s = STAMP_W'($urandom_range(0, 65535));
      default: s = STAMP_W'($urandom_range(0, cur_period));
    endcase
    return s;
  endfunction

  task automatic random_item();
    int r;
    int k;
    r = $urandom_range(0, 99);
    if (r < 2) begin
      k = $urandom_range(2, 40);
      repeat (k) send_item(OP_OVF, CH_W'($urandom_range(0, 3)),
                           STAMP_W'($urandom_range(0, 65535)), 1'b0, '0);
    end else if (r < 7) begin
      send_item(OP_UNUSED, CH_W'($urandom_range(0, 3)),
                STAMP_W'($urandom_range(0, 65535)), 1'b0, '0);
    end else if (r < 42) begin
      send_item(OP_OVF, CH_W'($urandom_range(0, 3)),
                STAMP_W'($urandom_range(0, 65535)), 1'b0, '0);
    end else if (r < 84) begin
      send_item(OP_CAP, CH_W'($urandom_range(0, 3)), pick_stamp(), 1'b0, '0);
    end else begin
      send_item(OP_COLLECT, CH_W'($urandom_range(0, 3)),
                STAMP_W'($urandom_range(0, 65535)), 1'b0, '0);
    end
  endtask

  initial begin
    width_rec_t         pres;
    stim_row_t          row;
    logic [STAMP_W-1:0] periods [N_PHASES];
    periods = '{16'h0000, 16'hFFFF, 16'h0001, 16'h0000,
                16'h8000, 16'h0000, 16'hFFFE, 16'h0000};
    periods[3] = STAMP_W'($urandom_range(2, 255));
    periods[5] = STAMP_W'($urandom_range(256, 65534));
    periods[7] = STAMP_W'($urandom_range(2, 65534));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    gap_pct = 30;
    for (int i = 0; i < N_DIRECTED; i++) begin
      row = DIRECTED[i];
      pres.processed = row.proc;
      pres.width[0]  = row.wa;
      pres.width[1]  = row.wb;
      pres.width[2]  = row.wc;
      pres.width[3]  = row.wd;
      send_item(row.opc, row.ch, row.st, row.pin, pres);
    end
    drain_results();

    for (int p = 0; p < N_PHASES; p++) begin
      write_period(periods[p]);
      cur_period = periods[p];
      gap_pct = (p == N_PHASES - 1) ? 0 : ((p % 2 == 0) ? 35 : 0);
      quiet <= (p == N_PHASES - 1);
      for (int i = 0; i < PHASE_ITEMS; i++) random_item();
      drain_results();
    end

    $display("summary: %0d events accepted, %0d width records checked, %0d mismatches",
             items_accepted, records_checked, mismatch_cnt);
    $display("summary: directed table, then random streams under %0d period_top settings",
             N_PHASES);
    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
